// ----- hw/rtl/imbe_pkg.sv -----
// Shared constants for the indirect map block estimator.
// No dependencies; used by indirect_map_block_estimator_unit.
`timescale 1ns / 1ps

package imbe_pkg;

  // Default number of direct slots in the block map.
  localparam int DIRECT_SLOTS = 12;

  // Width and clamp limits of the addresses-per-block log2 register.
  localparam int              L_W     = 4;
  localparam logic [L_W-1:0]  L_MIN   = 4'd8;
  localparam logic [L_W-1:0]  L_MAX   = 4'd14;
  localparam logic [L_W-1:0]  L_RESET = 4'd8;

  // Field widths.
  localparam int IDX_W   = 32;
  localparam int END_W   = 33;
  localparam int TOTAL_W = 33;

  // Region bounds reach D + A + A*A with A at most 2**14 and D at most 64.
  localparam int BOUND_W = 29;
  // Offset inside the double region, below A*A.
  localparam int OFF2_W  = 28;
  // Leaf count inside the double region, at most A.
  localparam int LEAF_W  = 15;
  // Triple region counts at the smallest L.
  localparam int T1_W    = 26;
  localparam int T2_W    = 18;

endpackage

// ----- hw/rtl/indirect_map_block_estimator_unit.sv -----
// Indirect map block estimator, top level.
// Depends on imbe_pkg for widths and register limits.
`timescale 1ns / 1ps

// The unit takes one item in every clock cycle and is never busy. Each item
// gives exactly one result, on total_blocks with done high for one cycle,
// after it passes the five register stages of the pipeline (input capture,
// end and region bounds, clipped offsets, shifted group counts, final sum in
// the output register). Results cannot be held off.
// The item carries the clamped addr_per_block_log2 with it, so the register
// should be written only while no item is in flight.
module indirect_map_block_estimator_unit #(
  parameter int DirectSlots = imbe_pkg::DIRECT_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [imbe_pkg::IDX_W-1:0]      start_index,
  input  logic [imbe_pkg::IDX_W-1:0]      range_length,
  output logic                            done,
  output logic [imbe_pkg::TOTAL_W-1:0]    total_blocks,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [imbe_pkg::L_W-1:0]        cfg_data
);

  localparam int LW = imbe_pkg::L_W;
  localparam int IW = imbe_pkg::IDX_W;
  localparam int EW = imbe_pkg::END_W;
  localparam int BW = imbe_pkg::BOUND_W;
  localparam int OW = imbe_pkg::OFF2_W;

  logic [LW-1:0] addr_per_block_log2;
  logic [LW-1:0] l_in;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_per_block_log2 <= imbe_pkg::L_RESET;
    end else if (cfg_valid && cfg_ready) begin
      addr_per_block_log2 <= cfg_data;
    end
  end

  always_comb begin
    if (addr_per_block_log2 < imbe_pkg::L_MIN) begin
      l_in = imbe_pkg::L_MIN;
    end else if (addr_per_block_log2 > imbe_pkg::L_MAX) begin
      l_in = imbe_pkg::L_MAX;
    end else begin
      l_in = addr_per_block_log2;
    end
  end

  // Stage A: captured item.
  logic          v_a;
  logic [IW-1:0] s_a, len_a;
  logic [LW-1:0] l_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else begin
      v_a <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s_a   <= start_index;
    len_a <= range_length;
    l_a   <= l_in;
  end

  // Stage B: range end and region bounds.
  logic          v_b, zero_b;
  logic [IW-1:0] s_b, len_b;
  logic [EW-1:0] e_b;
  logic [BW-1:0] b1_b, b2_b;
  logic [LW-1:0] l_b;
  logic [BW-1:0] b1_next, b2_next;
  logic [EW-1:0] e_next;

  assign e_next  = EW'(s_a) + EW'(len_a) - EW'(1);
  assign b1_next = BW'(DirectSlots) + (BW'(1) << l_a);
  assign b2_next = b1_next + (BW'(1) << {l_a, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    s_b    <= s_a;
    len_b  <= len_a;
    zero_b <= (len_a == '0);
    e_b    <= e_next;
    b1_b   <= b1_next;
    b2_b   <= b2_next;
    l_b    <= l_a;
  end

  // Stage C: region hits and clipped offsets.
  logic          v_c, zero_c, single_c, double_c, triple_c;
  logic [IW-1:0] len_c, ts_c;
  logic [OW-1:0] ds_c, de_c;
  logic [EW-1:0] te_c;
  logic [LW-1:0] l_c;
  logic [EW-1:0] b1_x, b2_x, s_x, e_clip;

  assign b1_x   = EW'(b1_b);
  assign b2_x   = EW'(b2_b);
  assign s_x    = EW'(s_b);
  assign e_clip = (e_b >= b2_x) ? (b2_x - EW'(1)) : e_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    len_c    <= len_b;
    zero_c   <= zero_b;
    l_c      <= l_b;
    single_c <= (s_x < b1_x) && (e_b >= EW'(DirectSlots));
    double_c <= (s_x < b2_x) && (e_b >= b1_x);
    triple_c <= (e_b >= b2_x);
    ds_c     <= (s_x < b1_x) ? '0 : OW'(s_x - b1_x);
    de_c     <= OW'(e_clip - b1_x);
    ts_c     <= (s_x < b2_x) ? '0 : IW'(s_x - b2_x);
    te_c     <= e_b - b2_x;
  end

  // Stage D: map block group counts.
  logic                          v_d, zero_d, single_d, double_d, triple_d;
  logic [IW-1:0]                 len_d;
  logic [imbe_pkg::LEAF_W-1:0]   leaf_d;
  logic [imbe_pkg::T1_W-1:0]     t1_d;
  logic [imbe_pkg::T2_W-1:0]     t2_d;
  logic [OW-1:0]                 de_sh, ds_sh;
  logic [EW-1:0]                 te_sh1, ts_sh1, te_sh2, ts_sh2;
  logic [LW:0]                   l2_c;

  assign l2_c   = {l_c, 1'b0};
  assign de_sh  = de_c >> l_c;
  assign ds_sh  = ds_c >> l_c;
  assign te_sh1 = te_c >> l_c;
  assign ts_sh1 = EW'(ts_c) >> l_c;
  assign te_sh2 = te_c >> l2_c;
  assign ts_sh2 = EW'(ts_c) >> l2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else begin
      v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    len_d    <= len_c;
    zero_d   <= zero_c;
    single_d <= single_c;
    double_d <= double_c;
    triple_d <= triple_c;
    leaf_d   <= imbe_pkg::LEAF_W'(de_sh - ds_sh + OW'(1));
    t1_d     <= imbe_pkg::T1_W'(te_sh1 - ts_sh1 + EW'(1));
    t2_d     <= imbe_pkg::T2_W'(te_sh2 - ts_sh2 + EW'(1));
  end

  // Stage E: data blocks plus map blocks.
  logic [imbe_pkg::T1_W+1:0]    meta;
  logic [imbe_pkg::TOTAL_W:0]   sum;

  always_comb begin
    meta = '0;
    if (single_d) begin
      meta = meta + ($bits(meta))'(1);
    end
    if (double_d) begin
      meta = meta + ($bits(meta))'(leaf_d) + ($bits(meta))'(1);
    end
    if (triple_d) begin
      meta = meta + ($bits(meta))'(t1_d) + ($bits(meta))'(t2_d) + ($bits(meta))'(1);
    end
    sum = ($bits(sum))'(len_d) + ($bits(sum))'(meta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    total_blocks <= zero_d ? '0 : sum[imbe_pkg::TOTAL_W-1:0];
  end

  // Every accepted item yields a result after the full pipeline depth.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##5 done)
    else $error("accepted item gave no result");

  // The total never counts fewer blocks than the range holds.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (total_blocks >= {1'b0, $past(range_length, 5)}))
    else $error("total below range length");

  // A nonempty range always occupies blocks; an empty one none.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ((total_blocks == '0) == ($past(range_length, 5) == '0)))
    else $error("zero result does not match zero length");

  // The shift amount carried by an item stays inside the clamp limits.
  assert property (@(posedge clk) disable iff (rst)
    v_a |-> (l_a >= imbe_pkg::L_MIN && l_a <= imbe_pkg::L_MAX))
    else $error("shift amount outside clamp limits");

endmodule

// ----- verif/indirect_map_block_estimator_unit_tb.sv -----
// Self-checking testbench for indirect_map_block_estimator_unit.
// Depends on imbe_pkg and the unit; it drives directed and random ranges
// under several register settings and compares each total against its own estimate.
`timescale 1ns / 1ps

module indirect_map_block_estimator_unit_tb;

  typedef struct packed {
    logic [imbe_pkg::IDX_W-1:0]   first_blk;
    logic [imbe_pkg::IDX_W-1:0]   blk_count;
    logic                         known;
    logic [imbe_pkg::TOTAL_W-1:0] total;
  } range_row_t;

  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 7;
  localparam int PER_PHASE  = 107;
  localparam int CYCLE_CAP  = 400000;

  // Typed totals hold for the reset setting of 256 addresses per block.
  localparam range_row_t DIRECTED [N_DIRECTED] = '{
    '{32'd0,          32'd0,          1'b1, 33'd0},
    '{32'hFFFF_FFFF,  32'd0,          1'b1, 33'd0},
    '{32'd0,          32'd1,          1'b1, 33'd1},
    '{32'd1,          32'd1,          1'b1, 33'd1},
    '{32'd0,          32'd12,         1'b1, 33'd12},
    '{32'd12,         32'd1,          1'b1, 33'd2},
    '{32'd11,         32'd2,          1'b1, 33'd3},
    '{32'd0,          32'd268,        1'b1, 33'd269},
    '{32'd268,        32'd1,          1'b1, 33'd3},
    '{32'd65804,      32'd1,          1'b1, 33'd4},
    '{32'd267,        32'd2,          1'b0, 33'd0},
    '{32'd65803,      32'd2,          1'b0, 33'd0},
    '{32'd268,        32'd65536,      1'b0, 33'd0},
    '{32'd524,        32'd256,        1'b0, 33'd0},
    '{32'd65804,      32'd65536,      1'b0, 33'd0},
    '{32'd0,          32'd65805,      1'b0, 33'd0},
    '{32'd0,          32'hFFFF_FFFF,  1'b0, 33'd0},
    '{32'hFFFF_FFFF,  32'd1,          1'b0, 33'd0},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 33'd0},
    '{32'h8000_0000,  32'h8000_0000,  1'b0, 33'd0},
    '{32'h5555_5555,  32'hAAAA_AAAA,  1'b0, 33'd0},
    '{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 33'd0}
  };

  localparam logic [imbe_pkg::L_W-1:0] LOG2_PLAN [N_PHASES] = '{
    4'd14, 4'd0, 4'd15, 4'd8, 4'd11, 4'd7, 4'd9
  };
  localparam int GAP_PLAN [N_PHASES] = '{0, 66, 12, 0, 66, 12, 0};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [imbe_pkg::IDX_W-1:0]   start_index = '0;
  logic [imbe_pkg::IDX_W-1:0]   range_length = '0;
  logic                         done;
  logic [imbe_pkg::TOTAL_W-1:0] total_blocks;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [imbe_pkg::L_W-1:0]     cfg_data = '0;

  logic [imbe_pkg::L_W-1:0]     log2_setting = imbe_pkg::L_RESET;
  logic [imbe_pkg::TOTAL_W-1:0] totals_due[$];
  int unsigned                  miss_count = 0;
  int unsigned                  cycle_count = 0;

  indirect_map_block_estimator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .start_index  (start_index),
    .range_length (range_length),
    .done         (done),
    .total_blocks (total_blocks),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned usable_log2(input logic [imbe_pkg::L_W-1:0] raw);
    if (raw < imbe_pkg::L_MIN) return imbe_pkg::L_MIN;
    if (raw > imbe_pkg::L_MAX) return imbe_pkg::L_MAX;
    return raw;
  endfunction

  function automatic logic [imbe_pkg::TOTAL_W-1:0] blocks_occupied(
      input logic [imbe_pkg::IDX_W-1:0] first_blk,
      input logic [imbe_pkg::IDX_W-1:0] blk_count,
      input logic [imbe_pkg::L_W-1:0] raw_log2);
    logic [63:0] s, e, a, b1, b2, sum, lead, os, oe;
    int unsigned lg;
    bit fin;
    lg = usable_log2(raw_log2);
    if (blk_count == '0) return '0;
    a = 64'd1 << lg;
    b1 = 64'(imbe_pkg::DIRECT_SLOTS) + a;
    b2 = b1 + a * a;
    s = 64'(first_blk);
    e = s + 64'(blk_count) - 64'd1;
    sum = '0;
    fin = 1'b0;
    if (s < 64'(imbe_pkg::DIRECT_SLOTS)) begin
      if (e < 64'(imbe_pkg::DIRECT_SLOTS)) begin
        sum = e - s + 1;
        fin = 1'b1;
      end else begin
        sum = 64'(imbe_pkg::DIRECT_SLOTS) - s;
        s = 64'(imbe_pkg::DIRECT_SLOTS);
      end
    end
    if (!fin && s < b1) begin
      if (e < b1) begin
        sum += e - s + 2;
        fin = 1'b1;
      end else begin
        sum += b1 - s + 1;
        s = b1;
      end
    end
    if (!fin && s < b2) begin
      lead = (s - b1) >> lg;
      if (e < b2) begin
        sum += e - s + 2 + (((e - b1) >> lg) - lead + 1);
        fin = 1'b1;
      end else begin
        sum += b2 - s + 1 + (a - lead);
        s = b2;
      end
    end
    if (!fin) begin
      os = s - b2;
      oe = e - b2;
      sum += e - s + 1;
      sum += (oe >> lg) - (os >> lg) + 1;
      sum += (oe >> (2 * lg)) - (os >> (2 * lg)) + 1;
      sum += 1;
    end
    return sum[imbe_pkg::TOTAL_W-1:0];
  endfunction

  task automatic pick_range(output logic [imbe_pkg::IDX_W-1:0] first_blk,
      output logic [imbe_pkg::IDX_W-1:0] blk_count);
    int unsigned lg;
    logic [63:0] a, b1, b2;
    lg = usable_log2(log2_setting);
    a = 64'd1 << lg;
    b1 = 64'(imbe_pkg::DIRECT_SLOTS) + a;
    b2 = b1 + a * a;
    case ($urandom_range(0, 9))
      0: begin
        first_blk = $urandom_range(0, 40);
        blk_count = $urandom_range(0, 300);
      end
      1: begin
        first_blk = b1[31:0] - $urandom_range(0, 20);
        blk_count = $urandom_range(1, 40);
      end
      2: begin
        first_blk = b1[31:0] + $urandom_range(0, 32'(a * a - 1));
        blk_count = $urandom_range(0, 1 << 20);
      end
      3: begin
        first_blk = b2[31:0] - $urandom_range(0, 32'(3 * a));
        blk_count = $urandom_range(0, 32'(5 * a));
      end
      4, 5: begin
        first_blk = $urandom;
        blk_count = $urandom;
      end
      6: begin
        first_blk = $urandom;
        blk_count = $urandom_range(0, 64);
      end
      7: begin
        first_blk = $urandom_range(0, 300);
        blk_count = $urandom;
      end
      8: begin
        first_blk = b2[31:0] + $urandom_range(0, 1 << 24);
        blk_count = $urandom_range(1, 1 << $urandom_range(8, 30));
      end
      default: begin
        first_blk = 32'hFFFF_FFFF - $urandom_range(0, 1 << 16);
        blk_count = $urandom;
      end
    endcase
  endtask

  task automatic pause_sender(input int pct);
    @(negedge clk);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic issue(input logic [imbe_pkg::IDX_W-1:0] first_blk,
      input logic [imbe_pkg::IDX_W-1:0] blk_count,
      input logic known, input logic [imbe_pkg::TOTAL_W-1:0] typed);
    start_index <= first_blk;
    range_length <= blk_count;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    totals_due.push_back(known ? typed : blocks_occupied(first_blk, blk_count, log2_setting));
  endtask

  task automatic drain_totals();
    @(negedge clk);
    start <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_log2(input logic [imbe_pkg::L_W-1:0] value);
    drain_totals();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    log2_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_miss(input logic [imbe_pkg::TOTAL_W-1:0] want,
      input logic [imbe_pkg::TOTAL_W-1:0] got, input bit orphan);
    if (miss_count < 10) begin
      if (orphan)
        $display("total_blocks: unexpected item, got %0d", got);
      else
        $display("total_blocks: expected %0d, got %0d", want, got);
    end
    miss_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (totals_due.size() == 0)
        note_miss('0, total_blocks, 1'b1);
      else if (totals_due[0] !== total_blocks)
        note_miss(totals_due.pop_front(), total_blocks, 1'b0);
      else
        void'(totals_due.pop_front());
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("indirect_map_block_estimator_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [imbe_pkg::IDX_W-1:0] first_blk, blk_count;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int r = 0; r < N_DIRECTED; r++) begin
      pause_sender(0);
      issue(DIRECTED[r].first_blk, DIRECTED[r].blk_count, DIRECTED[r].known,
            DIRECTED[r].total);
    end
    for (int p = 0; p < N_PHASES; p++) begin
      write_log2(LOG2_PLAN[p]);
      for (int i = 0; i < PER_PHASE; i++) begin
        if (i == PER_PHASE / 2) drain_totals();
        pause_sender(GAP_PLAN[p]);
        pick_range(first_blk, blk_count);
        issue(first_blk, blk_count, 1'b0, '0);
      end
    end
    drain_totals();
    repeat (10) @(posedge clk);
    if (miss_count == 0)
      $display("indirect_map_block_estimator_unit: match");
    else
      $display("indirect_map_block_estimator_unit: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/imbe_pkg.sv
hw/rtl/indirect_map_block_estimator_unit.sv
verif/indirect_map_block_estimator_unit_tb.sv
